[hdl/serial_frame_receiver_macros.svh]
// Assertion helpers shared by the receiver RTL
`ifndef SERIAL_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_MACROS_SVH

// Property checked on every clock, held off during reset
`define SFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge
`define SFR_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hdl/sfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_TICK    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RECV  = 3'b010,
		ST_READY = 3'b100
	} rx_fsm_t;

	localparam logic [1:0] RXS_IDLE  = 2'd0;
	localparam logic [1:0] RXS_RECV  = 2'd1;
	localparam logic [1:0] RXS_READY = 2'd2;

	localparam logic [2:0] REG_SOF_CHAR    = 3'd0;
	localparam logic [2:0] REG_EOF_LENGTH  = 3'd1;
	localparam logic [2:0] REG_EOF_STRING  = 3'd2;
	localparam logic [2:0] REG_BUFFER_SIZE = 3'd3;
	localparam logic [2:0] REG_TIMEOUT     = 3'd4;

	typedef struct packed {
		logic       we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic       re;
		logic [7:0] raddr;
	} buf_req_t;

	typedef struct packed {
		logic [1:0] rx_state;
		logic [7:0] frame_length;
		logic       frame_done;
		logic       frame_dropped;
		logic       byte_ignored;
		logic       rd_ok;
	} res_t;

	typedef struct packed {
		logic [1:0] rx_state;
		logic [7:0] frame_length;
		logic       frame_done;
		logic       frame_dropped;
		logic       byte_ignored;
		logic [7:0] read_data;
	} out_t;

	function automatic logic [1:0] state_code(rx_fsm_t st);
		logic [1:0] c;
		unique case (st)
			ST_RECV:  c = RXS_RECV;
			ST_READY: c = RXS_READY;
			default:  c = RXS_IDLE;
		endcase
		return c;
	endfunction

	// Newest byte sits in recent[7:0]; string byte 0 is the oldest of the window
	function automatic logic eof_match(logic [31:0] recent, logic [31:0] str, logic [2:0] len);
		logic ok;
		int   k;
		ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			k = int'(len) - 1 - i;
			if (i < int'(len)) begin
				if (recent[8*k +: 8] != str[8*i +: 8]) ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage
`default_nettype wire

[hdl/serial_frame_receiver.sv]
// Serial frame receiver: collects received bytes into frames in an on-chip buffer, opening on
// the start byte (any byte when it is 0), closing on an end string match or (end matching off)
// an idle timeout, dropping frames that time out with end matching on or reach the usable size
// less one. Each input item carries an opcode in tuser (byte, tick, release, read) and yields
// exactly one result item. One item is accepted per clock unless the output stalls; a result is
// registered with the buffer read port, then in the output register. Configuration is written
// through cfg_we, cfg_addr and cfg_wdata while no item is in flight; indexes 5 to 7 are ignored.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_frame_receiver_macros.svh"
module serial_frame_receiver
	import sfr_pkg::*;
#(
	parameter int BUF_DEPTH = 256,
	parameter int EOF_MAX   = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // rx_byte, read_index
	input  wire logic [1:0]  s_axis_tuser,  // opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // rx_state, frame_length, read_data, zero pad
	output logic             m_axis_tlast,  // frame_done
	output logic [1:0]       m_axis_tuser   // frame_dropped, byte_ignored
);
	logic     acc;
	buf_req_t req;
	res_t     res;
	logic [7:0] rdata;
	out_t     out;

	assign acc = s_axis_tvalid && s_axis_tready;

	sfr_ctrl #(
		.BUF_DEPTH(BUF_DEPTH),
		.EOF_MAX  (EOF_MAX)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.acc       (acc),
		.opcode    (s_axis_tuser),
		.rx_byte   (s_axis_tdata[7:0]),
		.read_index(s_axis_tdata[15:8]),
		.req       (req),
		.res       (res)
	);

	sfr_buf #(
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk  (clk),
		.req  (req),
		.rdata(rdata)
	);

	sfr_ostage u_ostage (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.res_in   (res),
		.rdata    (rdata),
		.ready    (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out      (out)
	);

	assign m_axis_tdata = {6'd0, out.read_data, out.frame_length, out.rx_state};
	assign m_axis_tlast = out.frame_done;
	assign m_axis_tuser = {out.byte_ignored, out.frame_dropped};

	`SFR_NEVER(a_done_and_drop, m_axis_tvalid && m_axis_tlast && m_axis_tuser[0], "frame both completed and dropped")
	`SFR_ASSERT(a_done_ready, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == RXS_READY, "completed frame not held ready")
	`SFR_ASSERT(a_drop_rearm, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[1:0] == RXS_IDLE && m_axis_tdata[9:2] == 8'd0, "dropped frame did not rearm")
	`SFR_ASSERT(a_rd_zero, m_axis_tvalid && m_axis_tdata[17:10] != 8'd0 |-> !m_axis_tlast && m_axis_tuser == 2'd0, "read data on a non-read result")
endmodule
`default_nettype wire

[hdl/sfr_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
module sfr_buf
	import sfr_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  wire logic     clk,
	input  wire buf_req_t req,
	output logic [7:0]    rdata
);
	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;

	assign wa = AW'(req.waddr);
	assign ra = AW'(req.raddr);

	always_ff @(posedge clk) begin
		if (req.we) mem[wa] <= req.wdata;
		if (req.re) rdata_q <= mem[ra];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[hdl/sfr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module sfr_ctrl
	import sfr_pkg::*;
#(
	parameter int BUF_DEPTH = 256,
	parameter int EOF_MAX   = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        acc,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  read_index,
	output buf_req_t         req,
	output res_t             res
);
	localparam logic [8:0] SIZE_LIM = 9'((BUF_DEPTH < 256) ? BUF_DEPTH : 256);
	localparam logic [2:0] EOF_LIM  = 3'((EOF_MAX < 4) ? EOF_MAX : 4);

	logic [7:0]  sof_q;
	logic [2:0]  eof_len_q;
	logic [31:0] eof_str_q;
	logic [8:0]  buf_size_q;
	logic [15:0] timeout_q;

	rx_fsm_t     st_q, st_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [15:0] tmr_q, tmr_d;
	logic [31:0] rec_q, rec_d;

	logic [8:0]  size_c;
	logic [8:0]  size_m1;
	logic [2:0]  elen;
	logic [7:0]  cnt_inc;
	logic [31:0] rec_sh;
	logic        done, dropped, ignored, rd_ok;
	op_t         op;

	assign op = op_t'(opcode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_q      <= '0;
			eof_len_q  <= '0;
			eof_str_q  <= '0;
			buf_size_q <= 9'd256;
			timeout_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SOF_CHAR:    sof_q      <= cfg_wdata[7:0];
				REG_EOF_LENGTH:  eof_len_q  <= cfg_wdata[2:0];
				REG_EOF_STRING:  eof_str_q  <= cfg_wdata;
				REG_BUFFER_SIZE: buf_size_q <= cfg_wdata[8:0];
				REG_TIMEOUT:     timeout_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		size_c = (buf_size_q > SIZE_LIM) ? SIZE_LIM : buf_size_q;
		if (size_c < 9'd3) size_c = 9'd3;
		size_m1 = size_c - 9'd1;
		elen    = (eof_len_q > EOF_LIM) ? EOF_LIM : eof_len_q;
	end

	assign cnt_inc = cnt_q + 8'd1;
	assign rec_sh  = {rec_q[23:0], rx_byte};

	always_comb begin
		st_d      = st_q;
		cnt_d     = cnt_q;
		tmr_d     = tmr_q;
		rec_d     = rec_q;
		done      = 1'b0;
		dropped   = 1'b0;
		ignored   = 1'b0;
		rd_ok     = 1'b0;
		req.we    = 1'b0;
		req.waddr = cnt_q;
		req.wdata = rx_byte;
		req.re    = acc && (op == OP_READ);
		req.raddr = read_index;
		unique case (op)
			OP_BYTE: begin
				unique case (st_q)
					ST_IDLE: begin
						if (rx_byte == sof_q || sof_q == 8'd0) begin
							req.we    = acc;
							req.waddr = 8'd0;
							cnt_d     = 8'd1;
							rec_d     = {24'd0, rx_byte};
							tmr_d     = timeout_q;
							st_d      = ST_RECV;
						end else begin
							ignored = 1'b1;
						end
					end
					ST_RECV: begin
						req.we = acc;
						cnt_d  = cnt_inc;
						rec_d  = rec_sh;
						if ({1'b0, cnt_inc} >= size_m1) begin
							st_d    = ST_IDLE;
							cnt_d   = '0;
							tmr_d   = '0;
							dropped = 1'b1;
						end else if (elen != 3'd0 && cnt_inc >= 8'(elen)
							&& eof_match(rec_sh, eof_str_q, elen)) begin
							st_d = ST_READY;
							done = 1'b1;
						end else begin
							tmr_d = timeout_q;
						end
					end
					ST_READY: ignored = 1'b1;
					default: ;
				endcase
			end
			OP_TICK: begin
				if (st_q == ST_RECV && timeout_q != 16'd0 && tmr_q != 16'd0) begin
					tmr_d = tmr_q - 16'd1;
					if (tmr_q == 16'd1) begin
						if (elen == 3'd0) begin
							st_d = ST_READY;
							done = 1'b1;
						end else begin
							st_d    = ST_IDLE;
							cnt_d   = '0;
							dropped = 1'b1;
						end
					end
				end
			end
			OP_RELEASE: begin
				st_d  = ST_IDLE;
				cnt_d = '0;
				tmr_d = '0;
			end
			OP_READ: rd_ok = read_index < cnt_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
			tmr_q <= '0;
			rec_q <= '0;
		end else if (acc) begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			tmr_q <= tmr_d;
			rec_q <= rec_d;
		end
	end

	assign res.rx_state      = state_code(st_d);
	assign res.frame_length  = cnt_d;
	assign res.frame_done    = done;
	assign res.frame_dropped = dropped;
	assign res.byte_ignored  = ignored;
	assign res.rd_ok         = rd_ok;
endmodule
`default_nettype wire

[hdl/sfr_ostage.sv]
`timescale 1ns / 1ps
`default_nettype none
module sfr_ostage
	import sfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       acc,
	input  wire res_t       res_in,
	input  wire logic [7:0] rdata,
	output logic            ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_t            out
);
	logic s1_valid_q;
	res_t res_s1;
	logic out_valid_q;
	out_t out_q;
	logic s1_move;

	assign s1_move = !out_valid_q || out_ready;
	assign ready   = !s1_valid_q || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready) s1_valid_q <= acc;
			if (s1_move) out_valid_q <= s1_valid_q;
		end
	end

	// Buffer read data lands in the cycle after the item is accepted; it holds while stage 1 stalls
	always_ff @(posedge clk) begin
		if (acc) res_s1 <= res_in;
		if (s1_move && s1_valid_q) begin
			out_q.rx_state      <= res_s1.rx_state;
			out_q.frame_length  <= res_s1.frame_length;
			out_q.frame_done    <= res_s1.frame_done;
			out_q.frame_dropped <= res_s1.frame_dropped;
			out_q.byte_ignored  <= res_s1.byte_ignored;
			out_q.read_data     <= res_s1.rd_ok ? rdata : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out       = out_q;
endmodule
`default_nettype wire

[bench/serial_frame_receiver_tb.sv]
`timescale 1ns / 1ps
module serial_frame_receiver_tb;
	import sfr_pkg::*;

	localparam int WD_LIMIT = 2000;

	typedef struct {
		op_t        op;
		logic [7:0] rx;
		logic [7:0] idx;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // rx_byte, read_index
	logic [1:0]  s_axis_tuser = '0;  // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // rx_state, frame_length, read_data, zero pad
	logic        m_axis_tlast;       // frame_done
	logic [1:0]  m_axis_tuser;       // frame_dropped, byte_ignored

	serial_frame_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// frame tracker state and its copy of the registers
	logic [7:0]  fs_mem [256];
	logic [1:0]  fs_state = RXS_IDLE;
	logic [7:0]  fs_count = '0;
	logic [15:0] fs_timer = '0;
	logic [31:0] fs_recent = '0;
	logic [7:0]  cf_sof = '0;
	logic [2:0]  cf_eof_len = '0;
	logic [31:0] cf_eof_str = '0;
	logic [8:0]  cf_bufsize = 9'd256;
	logic [15:0] cf_timeout = '0;

	rx_item_t stim_q[$];
	rx_item_t stim_cur;
	out_t     frame_result_q[$];
	out_t     want_r;
	out_t     got_r;
	int       n_made = 0;
	int       n_in = 0;
	int       n_out = 0;
	int       n_err = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	int       quiet_cyc = 0;

	function automatic int usable_len();
		if (cf_bufsize > 9'd256) return 256;
		if (cf_bufsize < 9'd3) return 3;
		return int'(cf_bufsize);
	endfunction

	function automatic int end_len();
		return (cf_eof_len > 3'd4) ? 4 : int'(cf_eof_len);
	endfunction

	function automatic void rearm_frame();
		fs_state = RXS_IDLE;
		fs_count = '0;
		fs_timer = '0;
	endfunction

	function automatic out_t frame_step(op_t op, logic [7:0] rx, logic [7:0] idx);
		out_t r;
		int   lim;
		int   elen;
		int   i;
		logic hit;
		r = '0;
		lim = usable_len();
		elen = end_len();
		case (op)
			OP_BYTE: begin
				if (fs_state == RXS_IDLE) begin
					if (rx == cf_sof || cf_sof == 8'd0) begin
						fs_mem[0] = rx;
						fs_count = 8'd1;
						fs_recent = {24'd0, rx};
						fs_timer = cf_timeout;
						fs_state = RXS_RECV;
					end else begin
						r.byte_ignored = 1'b1;
					end
				end else if (fs_state == RXS_RECV) begin
					fs_mem[fs_count] = rx;
					fs_count = fs_count + 8'd1;
					fs_recent = {fs_recent[23:0], rx};
					hit = 1'b1;
					for (i = 0; i < elen; i++)
						if (fs_recent[8*(elen-1-i) +: 8] != cf_eof_str[8*i +: 8]) hit = 1'b0;
					if (int'(fs_count) >= lim - 1) begin
						rearm_frame();
						r.frame_dropped = 1'b1;
					end else if (elen != 0 && int'(fs_count) >= elen && hit) begin
						fs_state = RXS_READY;
						r.frame_done = 1'b1;
					end else begin
						fs_timer = cf_timeout;
					end
				end else begin
					r.byte_ignored = 1'b1;
				end
			end
			OP_TICK: begin
				if (fs_state == RXS_RECV && cf_timeout != 0 && fs_timer != 0) begin
					fs_timer = fs_timer - 16'd1;
					if (fs_timer == 0) begin
						if (elen == 0) begin
							fs_state = RXS_READY;
							r.frame_done = 1'b1;
						end else begin
							rearm_frame();
							r.frame_dropped = 1'b1;
						end
					end
				end
			end
			OP_RELEASE: rearm_frame();
			OP_READ: begin
				if (idx < fs_count) r.read_data = fs_mem[idx];
			end
		endcase
		r.rx_state = fs_state;
		r.frame_length = fs_count;
		return r;
	endfunction

	task automatic add(input op_t op, input logic [7:0] v);
		rx_item_t it;
		it.op = op;
		it.rx = (op == OP_BYTE) ? v : 8'($urandom_range(0, 255));
		it.idx = (op == OP_READ) ? v : 8'($urandom_range(0, 254));
		stim_q.push_back(it);
		n_made++;
	endtask

	task automatic settle();
		while (stim_q.size() != 0 || s_axis_tvalid || frame_result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
	endtask

	task automatic set_cfg(input logic [7:0] sof, input logic [2:0] elen,
			input logic [31:0] estr, input logic [8:0] bsz, input logic [15:0] tmo);
		settle();
		cfg_write(REG_SOF_CHAR, {24'd0, sof});
		cfg_write(REG_EOF_LENGTH, {29'd0, elen});
		cfg_write(REG_EOF_STRING, estr);
		cfg_write(REG_BUFFER_SIZE, {23'd0, bsz});
		cfg_write(REG_TIMEOUT, {16'd0, tmo});
		@(posedge clk);
		cfg_we <= 1'b0;
		cf_sof = sof;
		cf_eof_len = elen;
		cf_eof_str = estr;
		cf_bufsize = bsz;
		cf_timeout = tmo;
	endtask

	// mostly well-formed frames with random content, the rest noise
	task automatic gen_frames(input int n);
		int stop, len, hi, k, elen;
		bit tshort;
		stop = n_made + n;
		elen = end_len();
		tshort = cf_timeout != 0 && cf_timeout <= 16'd8;
		hi = usable_len() > 40 ? 40 : usable_len();
		while (n_made < stop) begin
			if ($urandom_range(0, 99) < 25) begin
				add(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 254)));
			end else begin
				add(OP_RELEASE, 8'd0);
				if ($urandom_range(0, 9) == 0) add(OP_BYTE, 8'($urandom_range(0, 255)));
				add(OP_BYTE, cf_sof != 0 ? cf_sof : 8'($urandom_range(0, 255)));
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, hi)
					: $urandom_range(0, hi < 8 ? hi : 8);
				for (k = 0; k < len; k++) begin
					add(OP_BYTE, 8'($urandom_range(0, 255)));
					if ($urandom_range(0, 5) == 0)
						repeat (tshort ? $urandom_range(1, cf_timeout) : $urandom_range(1, 3))
							add(OP_TICK, 8'd0);
				end
				if (elen != 0 && $urandom_range(0, 4) != 0) begin
					for (k = 0; k < elen; k++) add(OP_BYTE, cf_eof_str[8*k +: 8]);
				end else if (tshort && $urandom_range(0, 1) == 0) begin
					repeat (cf_timeout) add(OP_TICK, 8'd0);
				end
				repeat ($urandom_range(0, 3))
					add(OP_READ, 8'($urandom_range(0, len + 3 > 254 ? 254 : len + 3)));
				if ($urandom_range(0, 2) == 0) add(OP_BYTE, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic field_chk(input string fname, input int want, input int got);
		if (want != got) begin
			if (n_err < 10)
				$display("result %0d: %s expected %0d, got %0d", n_out, fname, want, got);
			n_err++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				frame_result_q.push_back(frame_step(op_t'(s_axis_tuser), s_axis_tdata[7:0],
					s_axis_tdata[15:8]));
				n_in <= n_in + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (stim_q.size() != 0 &&
						((n_in >= 100 && n_in < 250) || $urandom_range(0, 99) >= 7)) begin
					stim_cur = stim_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {stim_cur.idx, stim_cur.rx};
					s_axis_tuser <= stim_cur.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_r.rx_state = m_axis_tdata[1:0];
				got_r.frame_length = m_axis_tdata[9:2];
				got_r.read_data = m_axis_tdata[17:10];
				got_r.frame_done = m_axis_tlast;
				got_r.frame_dropped = m_axis_tuser[0];
				got_r.byte_ignored = m_axis_tuser[1];
				if (frame_result_q.size() == 0) begin
					if (n_err < 10) $display("result %0d: no item expected", n_out);
					n_err++;
				end else begin
					want_r = frame_result_q.pop_front();
					field_chk("rx_state", want_r.rx_state, got_r.rx_state);
					field_chk("frame_length", want_r.frame_length, got_r.frame_length);
					field_chk("read_data", want_r.read_data, got_r.read_data);
					field_chk("frame_done", want_r.frame_done, got_r.frame_done);
					field_chk("frame_dropped", want_r.frame_dropped, got_r.frame_dropped);
					field_chk("byte_ignored", want_r.byte_ignored, got_r.byte_ignored);
					field_chk("pad", 0, m_axis_tdata[23:18]);
				end
				n_out <= n_out + 1;
			end
			// hold off once for a long stretch so the input side backs up
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && n_out == 320) begin
				hold_left <= 150;
				hold_done <= 1'b1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (n_out >= 100 && n_out < 250) || $urandom_range(0, 99) >= 7;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
				quiet_cyc <= 0;
			end else if (quiet_cyc >= WD_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cyc <= quiet_cyc + 1;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// end string with a zero byte, timeout drop, ignored bytes
		set_cfg(8'hFF, 3'd2, 32'h5A5A_000A, 9'd16, 16'd2);
		add(OP_BYTE, 8'h00);
		add(OP_TICK, 8'd0);
		add(OP_BYTE, 8'hFF);
		add(OP_BYTE, 8'h0A);
		add(OP_BYTE, 8'h00);
		add(OP_BYTE, 8'h55);
		add(OP_READ, 8'd0);
		add(OP_READ, 8'd1);
		add(OP_TICK, 8'd0);
		add(OP_RELEASE, 8'd0);
		add(OP_BYTE, 8'hFF);
		add(OP_TICK, 8'd0);
		add(OP_TICK, 8'd0);

		// buffer size below range, abandon while receiving, overflow
		set_cfg(8'h00, 3'd0, 32'h0, 9'd0, 16'd0);
		add(OP_BYTE, 8'h80);
		add(OP_RELEASE, 8'd0);
		add(OP_BYTE, 8'h80);
		add(OP_BYTE, 8'h7F);
		add(OP_READ, 8'd0);

		// end length and buffer size above range
		set_cfg(8'h00, 3'd7, 32'hFFFF_FFFF, 9'd511, 16'd1);
		repeat (4) add(OP_BYTE, 8'hFF);
		add(OP_RELEASE, 8'd0);
		add(OP_BYTE, 8'h01);
		add(OP_TICK, 8'd0);

		// timeout keeps the frame when end matching is off
		set_cfg(8'h3C, 3'd0, 32'h0, 9'd300, 16'd3);
		add(OP_BYTE, 8'h3C);
		add(OP_BYTE, 8'h00);
		repeat (3) add(OP_TICK, 8'd0);
		add(OP_READ, 8'd1);

		// fill the buffer up to the usable size less one and overflow at the largest size
		set_cfg(8'h00, 3'd0, 32'h0, 9'd256, 16'd0);
		add(OP_RELEASE, 8'd0);
		repeat (255) add(OP_BYTE, 8'($urandom_range(0, 255)));

		set_cfg(8'h7E, 3'd1, 32'h0000_007E, 9'd40, 16'd4);
		gen_frames(80);
		set_cfg(8'h00, 3'd3, $urandom(), 9'd12, 16'd3);
		gen_frames(80);
		set_cfg(8'h02, 3'd4, $urandom(), 9'd256, 16'd65535);
		gen_frames(80);
		set_cfg(8'h00, 3'd0, 32'h0, 9'd20, 16'd5);
		gen_frames(80);
		set_cfg(8'($urandom_range(1, 255)), 3'd2, $urandom(), 9'd3, 16'd1);
		gen_frames(60);
		set_cfg(8'hFF, 3'd5, $urandom(), 9'd30, 16'd2);
		gen_frames(80);

		settle();
		repeat (10) @(posedge clk);
		if (n_err == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
